// ===== sv/merp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merp_pkg
// Shared types and codes for the MIDI event record/playback unit.
// ----------------------------------------------------------------------------
package merp_pkg;

  localparam int KIND_W = 3;
  localparam int OFFS_W = 16;
  localparam int MSG_W  = 24;
  localparam int TS_W   = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_BLOCK_EVT = 3'd0,
    KIND_BLOCK_END = 3'd1,
    KIND_LIVE_EVT  = 3'd2,
    KIND_REC_START = 3'd3,
    KIND_REC_STOP  = 3'd4,
    KIND_PLAY_START = 3'd5,
    KIND_PLAY_STOP = 3'd6,
    KIND_CLEAR     = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    TR_IDLE = 2'd0,
    TR_REC  = 2'd1,
    TR_PLAY = 2'd2
  } transport_t;

  typedef struct packed {
    logic [TS_W-1:0]  ts;
    logic [MSG_W-1:0] msg;
  } evt_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OFFS_W-1:0] sample_offset;
    logic [MSG_W-1:0]  message;
    logic [OFFS_W-1:0] block_samples;
  } in_item_t;

  typedef struct packed {
    logic              event_valid;
    logic [MSG_W-1:0]  event_message;
    logic [OFFS_W-1:0] event_offset;
    logic              last;
    logic [1:0]        transport_state;
    logic [TS_W-1:0]   position_samples;
    logic [TS_W-1:0]   length_samples;
    logic              overflow;
  } out_item_t;

  // saturating add of a 16-bit amount to a 32-bit position
  function automatic logic [TS_W-1:0] sat_add(input logic [TS_W-1:0] a,
                                              input logic [OFFS_W-1:0] b);
    logic [TS_W:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[TS_W] ? {TS_W{1'b1}} : s[TS_W-1:0];
  endfunction

endpackage

// ===== sv/merp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merp_in_if / merp_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface merp_in_if
  import merp_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface merp_out_if
  import merp_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/merp_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merp_store
// Synchronous event memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module merp_store
  import merp_pkg::*;
#(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  evt_t          wdata,
  input  logic [AW-1:0] raddr,
  output evt_t          rdata
);

  evt_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/midi_event_record_playback_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_event_record_playback_unit
// Timestamped MIDI event store with record and playback transport.
// ----------------------------------------------------------------------------
// Channels: in_ carries commands and events (kind, sample_offset, message,
// block_samples); out_ returns results. Every input yields one status result,
// except a block end while playing that plays events, which yields one result
// per played event (up to MAX_BURST), the final one marked by last.
// Sequencing: a simple command or event passes through S_LEN_RD, S_LEN_WAIT
// and S_OUT, where its status result is loaded into the output register. A
// live insert scans the store from the bottom and then moves each later entry
// up one place; no new input is taken until it is done. A playing block end
// first counts the due events, then reads them again and sends them one by
// one, each waiting for the output register.
// Reset clears all control state; the memory holds no valid bits, entries
// above the fill count are never used. When the receiver stalls, the
// result waits in the output register and the unit holds; no input is taken
// until every result of the current one has been transferred.
// ----------------------------------------------------------------------------
module midi_event_record_playback_unit
  import merp_pkg::*;
#(
  parameter int EVENT_DEPTH = 16384,
  parameter int MAX_BURST   = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  merp_in_if.sink    in_ch,
  merp_out_if.source out_ch
);

  localparam int AW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int CW = $clog2(EVENT_DEPTH + 1);
  localparam int BW = $clog2(MAX_BURST + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR, S_LEN_RD,
    S_LEN_WAIT, S_PLAY_RD, S_PLAY_CHK, S_PLAY_END, S_EMIT_RD, S_EMIT_WR, S_OUT
  } state_t;

  state_t      state_r;
  in_item_t    item_r;
  logic [CW-1:0] count_r, idx_r, at_r;
  logic [TS_W-1:0] wpos_r, ppos_r, bstart_r, len_r;
  logic [CW-1:0] pidx_r;
  logic [1:0]  transport_r;
  logic        ovf_r;
  logic [BW-1:0] nemit_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  evt_t          mem_wdata, mem_rdata;
  logic          mem_we_f;
  logic [AW-1:0] mem_waddr_f;
  evt_t          mem_wdata_f;

  merp_store #(.DEPTH(EVENT_DEPTH), .AW(AW)) u_store (
    .clk  (clk),
    .we   (mem_we_f),
    .waddr(mem_waddr_f),
    .wdata(mem_wdata_f),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // output register takes a new result when it is free or being drained
  logic out_load;
  assign out_load = (!out_valid_r || out_ch.ready) &&
                    ((state_r == S_OUT) || (state_r == S_EMIT_WR));

  // block end as 33-bit compare value
  logic [TS_W:0] bend;
  assign bend = {1'b0, ppos_r} + {17'd0, item_r.block_samples};

  // play position at the end of the current block
  logic [TS_W-1:0] ppos_end;
  assign ppos_end = sat_add(ppos_r, item_r.block_samples);

  // clamped offset of the entry just read
  logic [TS_W-1:0] diff;
  logic [OFFS_W-1:0] clamp_off;
  always_comb begin
    diff = mem_rdata.ts - ppos_r;
    if (mem_rdata.ts <= ppos_r) begin
      clamp_off = '0;
    end else if (diff > {16'd0, item_r.block_samples - 16'd1}) begin
      clamp_off = item_r.block_samples - 16'd1;
    end else begin
      clamp_off = diff[OFFS_W-1:0];
    end
  end

  // memory access steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = idx_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        mem_we    = in_ch.valid && in_ch.ready &&
                    (in_ch.data.kind == KIND_BLOCK_EVT) &&
                    (transport_r == TR_REC) && (count_r < CW'(EVENT_DEPTH));
        mem_waddr = count_r[AW-1:0];
        mem_wdata.ts  = sat_add(wpos_r, in_ch.data.sample_offset);
        mem_wdata.msg = in_ch.data.message;
      end
      S_SHIFT_RD: begin
        // fetch the entry below the slot being filled
        mem_raddr = AW'(idx_r - CW'(1));
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_r + CW'(1));
        mem_wdata = mem_rdata;
      end
      S_SCAN_CHK: begin
        mem_we = 1'b0;
      end
      S_LEN_RD: begin
        mem_raddr = AW'(count_r - CW'(1));
      end
      default: ;
    endcase
  end

  // live insert write of the new entry
  logic ins_we;
  assign ins_we = (state_r == S_SHIFT_RD) && (idx_r == at_r);

  always_comb begin
    mem_we_f    = mem_we;
    mem_waddr_f = mem_waddr;
    mem_wdata_f = mem_wdata;
    if (ins_we) begin
      mem_we_f      = 1'b1;
      mem_waddr_f   = at_r[AW-1:0];
      mem_wdata_f.ts  = bstart_r;
      mem_wdata_f.msg = item_r.message;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wpos_r      <= '0;
      ppos_r      <= '0;
      pidx_r      <= '0;
      bstart_r    <= '0;
      transport_r <= TR_IDLE;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      len_r       <= '0;
      idx_r       <= '0;
      at_r        <= '0;
      nemit_r     <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            item_r  <= in_ch.data;
            nemit_r <= '0;
            state_r <= S_LEN_RD;
            unique case (kind_t'(in_ch.data.kind))
              KIND_BLOCK_EVT: begin
                if (transport_r == TR_REC) begin
                  if (count_r < CW'(EVENT_DEPTH)) count_r <= count_r + CW'(1);
                  else ovf_r <= 1'b1;
                end
              end
              KIND_BLOCK_END: begin
                if (in_ch.data.block_samples != '0) begin
                  if (transport_r == TR_REC) begin
                    bstart_r <= wpos_r;
                    wpos_r   <= sat_add(wpos_r, in_ch.data.block_samples);
                  end else if (transport_r == TR_PLAY) begin
                    idx_r   <= pidx_r;
                    state_r <= S_PLAY_RD;
                  end
                end
              end
              KIND_LIVE_EVT: begin
                if (transport_r == TR_REC) begin
                  if (count_r < CW'(EVENT_DEPTH)) begin
                    idx_r   <= '0;
                    state_r <= S_SCAN_RD;
                  end else begin
                    ovf_r <= 1'b1;
                  end
                end
              end
              KIND_REC_START: begin
                count_r <= '0; bstart_r <= '0; ovf_r <= 1'b0;
                wpos_r  <= '0; transport_r <= TR_REC;
              end
              KIND_REC_STOP: begin
                if (transport_r == TR_REC) transport_r <= TR_IDLE;
              end
              KIND_PLAY_START: begin
                if (count_r != '0) begin
                  ppos_r <= '0; pidx_r <= '0; transport_r <= TR_PLAY;
                end
              end
              KIND_PLAY_STOP: begin
                if (transport_r == TR_PLAY) transport_r <= TR_IDLE;
              end
              KIND_CLEAR: begin
                count_r <= '0; bstart_r <= '0; ovf_r <= 1'b0;
                wpos_r <= '0; ppos_r <= '0; pidx_r <= '0;
                transport_r <= TR_IDLE;
              end
            endcase
          end
        end
        // linear scan for the first entry stamped after block_start
        S_SCAN_RD: begin
          if (idx_r == count_r) begin
            at_r    <= count_r;
            idx_r   <= count_r;
            state_r <= S_SHIFT_RD;
          end else begin
            state_r <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (mem_rdata.ts > bstart_r) begin
            at_r    <= idx_r;
            idx_r   <= count_r;
            state_r <= S_SHIFT_RD;
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_SCAN_RD;
          end
        end
        // move entries up from the top down to at
        S_SHIFT_RD: begin
          if (idx_r == at_r) begin
            count_r <= count_r + CW'(1);
            state_r <= S_LEN_RD;
          end else begin
            idx_r   <= idx_r - CW'(1);
            state_r <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          state_r <= S_SHIFT_RD;
        end
        // playback: count the events due in this block
        S_PLAY_RD: begin
          if (nemit_r == BW'(MAX_BURST) || idx_r >= count_r) begin
            state_r <= S_PLAY_END;
          end else begin
            state_r <= S_PLAY_CHK;
          end
        end
        S_PLAY_CHK: begin
          if ({1'b0, mem_rdata.ts} < bend) begin
            idx_r   <= idx_r + CW'(1);
            nemit_r <= nemit_r + BW'(1);
            state_r <= S_PLAY_RD;
          end else begin
            state_r <= S_PLAY_END;
          end
        end
        // transport after the block is known before any event goes out
        S_PLAY_END: begin
          if (idx_r >= count_r) transport_r <= TR_IDLE;
          if (nemit_r == '0) begin
            ppos_r  <= ppos_end;
            state_r <= S_LEN_RD;
          end else begin
            at_r    <= idx_r;
            idx_r   <= pidx_r;
            state_r <= S_EMIT_RD;
          end
        end
        // playback: read the counted events again and send them
        S_EMIT_RD: begin
          state_r <= S_EMIT_WR;
        end
        S_EMIT_WR: begin
          if (out_load) begin
            out_data_r.event_valid     <= 1'b1;
            out_data_r.event_message   <= mem_rdata.msg;
            out_data_r.event_offset    <= clamp_off;
            out_data_r.last            <= (idx_r + CW'(1) == at_r);
            out_data_r.transport_state <= transport_r;
            out_data_r.position_samples <=
              (transport_r == TR_PLAY) ? ppos_end : wpos_r;
            out_data_r.length_samples  <= len_r;
            out_data_r.overflow        <= ovf_r;
            idx_r <= idx_r + CW'(1);
            if (idx_r + CW'(1) == at_r) begin
              ppos_r  <= ppos_end;
              pidx_r  <= at_r;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_EMIT_RD;
            end
          end
        end
        S_LEN_RD: begin
          state_r <= S_LEN_WAIT;
        end
        S_LEN_WAIT: begin
          len_r   <= (count_r != '0) ? mem_rdata.ts : '0;
          state_r <= S_OUT;
        end
        // status result
        S_OUT: begin
          if (out_load) begin
            out_data_r.event_valid   <= 1'b0;
            out_data_r.event_message <= '0;
            out_data_r.event_offset  <= '0;
            out_data_r.last          <= 1'b1;
            out_data_r.transport_state <= transport_r;
            out_data_r.position_samples <=
              (transport_r == TR_PLAY) ? ppos_r : wpos_r;
            out_data_r.length_samples <= len_r;
            out_data_r.overflow       <= ovf_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
